### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/i2cm_pkg.sv
// Types and codes of the I2C register-access master.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam logic [15:0] DELAY_RESET = 16'd100;

	typedef struct packed {
		logic       kind;
		logic       is_read;
		logic [7:0] slave_address;
		logic [7:0] register_address;
		logic [7:0] write_data;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       ok;
		logic [7:0] read_data;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'd0,
		ST_S0   = 5'd1,
		ST_S1   = 5'd2,
		ST_S2   = 5'd3,
		ST_T0   = 5'd4,
		ST_T1   = 5'd5,
		ST_T2   = 5'd6,
		ST_A0   = 5'd7,
		ST_A1   = 5'd8,
		ST_A2   = 5'd9,
		ST_A3   = 5'd10,
		ST_R0   = 5'd11,
		ST_R1   = 5'd12,
		ST_P0   = 5'd13,
		ST_P1   = 5'd14,
		ST_P2   = 5'd15,
		ST_P3   = 5'd16
	} state_t;

	// Which part of the transaction is running.
	typedef enum logic [2:0] {
		STG_START    = 3'd0,
		STG_SLAVE    = 3'd1,
		STG_REGISTER = 3'd2,
		STG_RESTART  = 3'd3,
		STG_SLAVE_RD = 3'd4,
		STG_READ     = 3'd5,
		STG_SUCCESS  = 3'd6,
		STG_NACK     = 3'd7
	} stage_t;

endpackage

### rtl/i2c_master_register_access.sv
// Top level of the I2C single-register read/write master.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

// Usage:
//   req channel (req_valid/req_stall/req): one request per bus-sequencer tick.
//   kind = 0 is a plain tick; kind = 1 starts a register write or read when
//   idle and is treated as a tick otherwise. sda_in is the sampled SDA level.
//   rsp channel (rsp_valid/rsp_stall/rsp): exactly one response per request,
//   in order, with the SCL/SDA release levels, busy, done, ok and read_data.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes delay_ticks, the number
//   of ticks per bus phase; write it only while the block is idle.
// Timing: a request goes into an input register, is evaluated against the
//   sequencer state and lands in the response register. One request per
//   cycle is sustained while rsp_stall does not hold a full response
//   register; the rate is set by the single input-to-response register
//   pair around the sequencer update.
// Reset: arst_n clears the sequencer to idle, both lines released, counters
//   and received byte zero, delay_ticks = 100, both register stages empty.
// Stall: while rsp_stall holds a full response register, the input register
//   holds and req_stall rises; nothing is dropped.
module i2c_master_register_access (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  i2cm_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output i2cm_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [15:0]     cfg_data
);

	logic             req_valid_s1;
	i2cm_pkg::req_t   req_s1;
	logic             advance;

	logic [15:0]      delay_q;
	i2cm_pkg::state_t state_q, state_d;
	i2cm_pkg::stage_t stage_q, stage_d;
	logic [15:0]      phase_q, phase_d;
	logic [2:0]       bit_q, bit_d;
	logic [7:0]       shift_q, shift_d;
	logic [7:0]       slave_q, slave_d;
	logic [7:0]       regaddr_q, regaddr_d;
	logic [7:0]       data_q, data_d;
	logic             is_read_q, is_read_d;
	logic             scl_q, scl_d;
	logic             sda_q, sda_d;
	logic [7:0]       rx_q, rx_d;

	logic             enter_en;
	logic             tx_go;
	i2cm_pkg::stage_t tx_stage;
	logic [7:0]       tx_byte;
	logic             end_go;
	logic             end_ok;
	logic             phase_end;
	logic [16:0]      phase_inc;
	i2cm_pkg::rsp_t   rsp_d;

	assign advance   = req_valid_s1 && (!rsp_valid || !rsp_stall);
	assign req_stall = req_valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	assign phase_inc = {1'b0, phase_q} + 17'd1;
	assign phase_end = phase_inc >= {1'b0, delay_q};

	always_comb begin
		state_d   = state_q;
		stage_d   = stage_q;
		phase_d   = phase_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		slave_d   = slave_q;
		regaddr_d = regaddr_q;
		data_d    = data_q;
		is_read_d = is_read_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		rx_d      = rx_q;
		enter_en  = 1'b0;
		tx_go     = 1'b0;
		tx_stage  = i2cm_pkg::STG_SLAVE;
		tx_byte   = slave_q;
		end_go    = 1'b0;
		end_ok    = 1'b0;

		if (state_q == i2cm_pkg::ST_IDLE) begin
			if (req_s1.kind) begin
				is_read_d = req_s1.is_read;
				slave_d   = req_s1.slave_address;
				regaddr_d = req_s1.register_address;
				data_d    = req_s1.write_data;
				stage_d   = i2cm_pkg::STG_START;
				bit_d     = 3'd0;
				state_d   = i2cm_pkg::ST_S0;
				phase_d   = 16'd0;
				enter_en  = 1'b1;
			end
		end else if (phase_end) begin
			phase_d = 16'd0;
			unique case (state_q) inside
				i2cm_pkg::ST_S0, i2cm_pkg::ST_S1: begin
					// S0 must see SDA high, S1 must see it low
					if ((state_q == i2cm_pkg::ST_S0) ? !req_s1.sda_in : req_s1.sda_in) begin
						if (stage_q == i2cm_pkg::STG_START) begin
							end_go = 1'b1;
						end else begin
							tx_go    = 1'b1;
							tx_stage = i2cm_pkg::STG_SLAVE_RD;
							tx_byte  = slave_q + 8'h01;
						end
					end else begin
						state_d  = (state_q == i2cm_pkg::ST_S0) ? i2cm_pkg::ST_S1
							: i2cm_pkg::ST_S2;
						enter_en = 1'b1;
					end
				end
				i2cm_pkg::ST_S2: begin
					tx_go = 1'b1;
					if (stage_q == i2cm_pkg::STG_START) begin
						tx_stage = i2cm_pkg::STG_SLAVE;
						tx_byte  = slave_q;
					end else begin
						tx_stage = i2cm_pkg::STG_SLAVE_RD;
						tx_byte  = slave_q + 8'h01;
					end
				end
				i2cm_pkg::ST_T0: begin
					state_d  = i2cm_pkg::ST_T1;
					enter_en = 1'b1;
				end
				i2cm_pkg::ST_T1: begin
					state_d  = i2cm_pkg::ST_T2;
					enter_en = 1'b1;
				end
				i2cm_pkg::ST_T2: begin
					shift_d  = {shift_q[6:0], 1'b0};
					enter_en = 1'b1;
					if (bit_q == 3'd7) begin
						bit_d   = 3'd0;
						state_d = i2cm_pkg::ST_A0;
					end else begin
						bit_d   = bit_q + 3'd1;
						state_d = i2cm_pkg::ST_T0;
					end
				end
				i2cm_pkg::ST_A0: begin
					state_d  = i2cm_pkg::ST_A1;
					enter_en = 1'b1;
				end
				i2cm_pkg::ST_A1: begin
					state_d  = i2cm_pkg::ST_A2;
					enter_en = 1'b1;
				end
				i2cm_pkg::ST_A2: begin
					if (stage_q == i2cm_pkg::STG_SLAVE && req_s1.sda_in) begin
						stage_d = i2cm_pkg::STG_NACK;
					end
					state_d  = i2cm_pkg::ST_A3;
					enter_en = 1'b1;
				end
				i2cm_pkg::ST_A3: begin
					case (stage_q)
						i2cm_pkg::STG_SLAVE: begin
							tx_go    = 1'b1;
							tx_stage = i2cm_pkg::STG_REGISTER;
							tx_byte  = regaddr_q;
						end
						i2cm_pkg::STG_REGISTER: begin
							if (is_read_q) begin
								stage_d  = i2cm_pkg::STG_RESTART;
								state_d  = i2cm_pkg::ST_S0;
								enter_en = 1'b1;
							end else begin
								tx_go    = 1'b1;
								tx_stage = i2cm_pkg::STG_RESTART;
								tx_byte  = data_q;
							end
						end
						i2cm_pkg::STG_SLAVE_RD: begin
							stage_d  = i2cm_pkg::STG_READ;
							shift_d  = 8'd0;
							bit_d    = 3'd0;
							state_d  = i2cm_pkg::ST_R0;
							enter_en = 1'b1;
						end
						i2cm_pkg::STG_NACK: begin
							state_d  = i2cm_pkg::ST_P0;
							enter_en = 1'b1;
						end
						default: begin
							stage_d  = i2cm_pkg::STG_SUCCESS;
							state_d  = i2cm_pkg::ST_P0;
							enter_en = 1'b1;
						end
					endcase
				end
				i2cm_pkg::ST_R0: begin
					state_d  = i2cm_pkg::ST_R1;
					enter_en = 1'b1;
				end
				i2cm_pkg::ST_R1: begin
					shift_d  = {shift_q[6:0], req_s1.sda_in};
					enter_en = 1'b1;
					if (bit_q == 3'd7) begin
						rx_d    = shift_d;
						bit_d   = 3'd0;
						state_d = i2cm_pkg::ST_A0;
					end else begin
						bit_d   = bit_q + 3'd1;
						state_d = i2cm_pkg::ST_R0;
					end
				end
				i2cm_pkg::ST_P0: begin
					state_d  = i2cm_pkg::ST_P1;
					enter_en = 1'b1;
				end
				i2cm_pkg::ST_P1: begin
					state_d  = i2cm_pkg::ST_P2;
					enter_en = 1'b1;
				end
				i2cm_pkg::ST_P2: begin
					state_d  = i2cm_pkg::ST_P3;
					enter_en = 1'b1;
				end
				i2cm_pkg::ST_P3: begin
					end_go = 1'b1;
					end_ok = (stage_q == i2cm_pkg::STG_SUCCESS);
				end
				default: begin
					end_go = 1'b1;
				end
			endcase
		end else begin
			phase_d = phase_inc[15:0];
		end

		if (tx_go) begin
			stage_d  = tx_stage;
			shift_d  = tx_byte;
			bit_d    = 3'd0;
			state_d  = i2cm_pkg::ST_T0;
			enter_en = 1'b1;
		end
		if (end_go) begin
			state_d = i2cm_pkg::ST_IDLE;
			phase_d = 16'd0;
		end

		// line levels set on entry to a phase
		if (enter_en) begin
			unique case (state_d) inside
				i2cm_pkg::ST_S0: begin
					scl_d = 1'b1;
					sda_d = 1'b1;
				end
				i2cm_pkg::ST_S1, i2cm_pkg::ST_S2, i2cm_pkg::ST_P1: sda_d = 1'b0;
				i2cm_pkg::ST_T0, i2cm_pkg::ST_A0, i2cm_pkg::ST_A3, i2cm_pkg::ST_P0:
					scl_d = 1'b0;
				i2cm_pkg::ST_T1: sda_d = shift_d[7];
				i2cm_pkg::ST_T2, i2cm_pkg::ST_A2, i2cm_pkg::ST_R1, i2cm_pkg::ST_P2:
					scl_d = 1'b1;
				i2cm_pkg::ST_A1, i2cm_pkg::ST_P3: sda_d = 1'b1;
				i2cm_pkg::ST_R0: begin
					scl_d = 1'b0;
					sda_d = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		rsp_d.scl_release = scl_d;
		rsp_d.sda_release = sda_d;
		rsp_d.busy_res    = (state_d != i2cm_pkg::ST_IDLE);
		rsp_d.done_res    = end_go;
		rsp_d.ok          = end_go && end_ok;
		rsp_d.read_data   = rx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid    <= 1'b0;
			delay_q      <= i2cm_pkg::DELAY_RESET;
			state_q      <= i2cm_pkg::ST_IDLE;
			stage_q      <= i2cm_pkg::STG_START;
			phase_q      <= 16'd0;
			bit_q        <= 3'd0;
			shift_q      <= 8'd0;
			slave_q      <= 8'd0;
			regaddr_q    <= 8'd0;
			data_q       <= 8'd0;
			is_read_q    <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			rx_q         <= 8'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				delay_q <= cfg_data;
			end
			if (!req_stall) begin
				req_valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid <= 1'b1;
				state_q   <= state_d;
				stage_q   <= stage_d;
				phase_q   <= phase_d;
				bit_q     <= bit_d;
				shift_q   <= shift_d;
				slave_q   <= slave_d;
				regaddr_q <= regaddr_d;
				data_q    <= data_d;
				is_read_q <= is_read_d;
				scl_q     <= scl_d;
				sda_q     <= sda_d;
				rx_q      <= rx_d;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp <= rsp_d;
		end
	end

endmodule

### rtl/i2cm_checker.sv
// Port-level checks for the I2C register-access master, bound to the top level.
// Depends on i2cm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input i2cm_pkg::rsp_t rsp
);

	// ok only accompanies done
	`ASSERT_IMPLIES(a_ok_with_done, clk, arst_n, rsp_valid && rsp.ok, rsp.done_res)
	// a finished transaction leaves the block idle
	`ASSERT_IMPLIES(a_done_not_busy, clk, arst_n, rsp_valid && rsp.done_res, !rsp.busy_res)
	// input back-pressure only comes from a held response
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, req_stall, rsp_valid && rsp_stall)
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (.*);
